// File: rtl/ipsc_pkg.sv
package ipsc_pkg;

    localparam int TGT_W   = 13;
    localparam int SPD_W   = 14;
    localparam int DRV_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int ERR_W   = 15;
    localparam int DERR_W  = 16;
    localparam int OUT_W   = 18;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // Product sum width: (kp * derr) + (ki * err) with margin
    localparam int ACC_W   = GAIN_W + DERR_W + 2;

    localparam int OUT18_MAX = 131071;
    localparam int OUT18_MIN = -131072;

    localparam logic [GAIN_W-1:0] KP_RESET   = 24'd681574;
    localparam logic [GAIN_W-1:0] KI_RESET   = 24'd2097;
    localparam logic [DRV_W-1:0]  OMAX_RESET = 16'd1400;
    localparam logic [DRV_W-1:0]  OMIN_RESET = 16'd50;
    localparam logic [TGT_W-1:0]  TMIN_RESET = 13'd100;
    localparam logic [TGT_W-1:0]  TMAX_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN    = 3'd0,
        REG_KI_GAIN    = 3'd1,
        REG_OUT_MAX    = 3'd2,
        REG_OUT_MIN    = 3'd3,
        REG_TARGET_MIN = 3'd4,
        REG_TARGET_MAX = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [TGT_W-1:0] target_request;
        logic [SPD_W-1:0] measured_speed;
    } t_pi_in;

    typedef struct packed {
        logic [DRV_W-1:0] drive;
        logic             integrating;
    } t_pi_out;

endpackage

// File: rtl/incremental_pi_speed_controller_unit.sv
// Incremental PI speed controller with anti-windup.
// Input channel: i_in_valid / o_in_stall carry one sample (target request and
// measured speed) per transfer. Output channel: o_out_valid / i_out_stall carry
// one result (clamped drive and integrating flag) per input sample, in order.
// Configuration: gains, drive limits and target window are written through
// i_cfg_wr_en / i_cfg_index / i_cfg_data; the user must write them only while
// no sample is in flight (the block does not enforce this). Throughput: one
// sample per cycle unless the receiver stalls. Stages after the input register:
// error/delta, gain multiplier, scale-and-truncate and output register.
// The output recursion (previous output plus increment, saturation, anti-windup
// decision) closes inside the last stage, so samples follow back to back.
// Reset (synchronous, active low) empties the pipeline, loads the default
// gains and limits, clears the stored error and sets the stored output to the
// default lower drive limit.
// When the receiver stalls, the result holds in the output register; empty
// stages still fill, and o_in_stall rises once every stage holds a sample.
module incremental_pi_speed_controller_unit
    import ipsc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_pi_in               i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_pi_out              o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int INC_W = ACC_W - GAIN_FRAC_BITS;
    localparam int SUM_W = ((INC_W > OUT_W) ? INC_W : OUT_W) + 1;
    localparam logic signed [ACC_W-1:0] RND =
        ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT18_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT18_MIN);
    localparam logic signed [OUT_W-1:0] PREV_OUT_RESET = OUT_W'(OMIN_RESET);

    // configuration
    logic [GAIN_W-1:0] r_kp, r_ki;
    logic [DRV_W-1:0]  r_omax, r_omin;
    logic [TGT_W-1:0]  r_tmin, r_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= KP_RESET;
            r_ki   <= KI_RESET;
            r_omax <= OMAX_RESET;
            r_omin <= OMIN_RESET;
            r_tmin <= TMIN_RESET;
            r_tmax <= TMAX_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KP_GAIN:    r_kp   <= i_cfg_data;
                REG_KI_GAIN:    r_ki   <= i_cfg_data;
                REG_OUT_MAX:    r_omax <= i_cfg_data[DRV_W-1:0];
                REG_OUT_MIN:    r_omin <= i_cfg_data[DRV_W-1:0];
                REG_TARGET_MIN: r_tmin <= i_cfg_data[TGT_W-1:0];
                REG_TARGET_MAX: r_tmax <= i_cfg_data[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and advance chain
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_v4 || !i_out_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign o_in_stall  = !rdy0;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_in_valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 0: input register
    t_pi_in r_in;
    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in_valid) r_in <= i_in_data;
    end

    // stage 1: clamp target, error and error delta
    logic [TGT_W-1:0]         w_tgt;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [DERR_W-1:0] w_derr;
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [ERR_W-1:0]  r_err1;
    logic signed [DERR_W-1:0] r_derr1;
    logic                     adv1;

    always_comb begin
        if (r_in.target_request < r_tmin)
            w_tgt = r_tmin;
        else if (r_in.target_request > r_tmax)
            w_tgt = r_tmax;
        else
            w_tgt = r_in.target_request;
    end

    assign w_err  = $signed({2'b00, w_tgt}) - $signed({1'b0, r_in.measured_speed});
    assign w_derr = $signed({w_err[ERR_W-1], w_err})
                  - $signed({r_prev_err[ERR_W-1], r_prev_err});
    assign adv1   = rdy1 && r_v0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_prev_err <= '0;
        else if (adv1)
            r_prev_err <= w_err;
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_err1  <= w_err;
            r_derr1 <= w_derr;
        end
    end

    // stage 2: gain products
    logic signed [GAIN_W+DERR_W:0]  w_pkp;
    logic signed [GAIN_W+ERR_W:0]   w_pki;
    logic signed [GAIN_W+DERR_W:0]  r_pkp;
    logic signed [GAIN_W+ERR_W:0]   r_pki;
    logic signed [ERR_W-1:0]        r_err2;

    assign w_pkp = $signed({1'b0, r_kp}) * r_derr1;
    assign w_pki = $signed({1'b0, r_ki}) * r_err1;

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_pkp  <= w_pkp;
            r_pki  <= w_pki;
            r_err2 <= r_err1;
        end
    end

    // stage 3: scale both candidate increments, truncating toward zero
    logic signed [ACC_W-1:0] w_acc_on, w_acc_off, w_rnd_on, w_rnd_off;
    logic signed [INC_W-1:0] r_inc_on, r_inc_off;
    logic signed [ERR_W-1:0] r_err3;

    assign w_acc_off = ACC_W'(r_pkp);
    assign w_acc_on  = ACC_W'(r_pkp) + ACC_W'(r_pki);
    assign w_rnd_on  = w_acc_on  + (w_acc_on[ACC_W-1]  ? RND : '0);
    assign w_rnd_off = w_acc_off + (w_acc_off[ACC_W-1] ? RND : '0);

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_inc_on  <= w_rnd_on[ACC_W-1:GAIN_FRAC_BITS];
            r_inc_off <= w_rnd_off[ACC_W-1:GAIN_FRAC_BITS];
            r_err3    <= r_err2;
        end
    end

    // stage 4: anti-windup, accumulate, saturate, clamp
    logic signed [OUT_W-1:0] r_prev_out;
    logic signed [OUT_W-1:0] w_omax_s, w_omin_s, w_uk;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_integ;
    logic [DRV_W-1:0]        w_drive;
    t_pi_out                 r_out;
    logic                    adv4;

    assign w_omax_s = $signed({2'b00, r_omax});
    assign w_omin_s = $signed({2'b00, r_omin});

    always_comb begin
        w_integ = 1'b1;
        if ((r_prev_out >= w_omax_s) && !r_err3[ERR_W-1])
            w_integ = 1'b0;
        if ((r_prev_out <= w_omin_s) && (r_err3[ERR_W-1] || (r_err3 == '0)))
            w_integ = 1'b0;
    end

    assign w_sum = SUM_W'(r_prev_out) + (w_integ ? SUM_W'(r_inc_on) : SUM_W'(r_inc_off));

    always_comb begin
        if (w_sum > SAT_HI)
            w_uk = OUT_W'(OUT18_MAX);
        else if (w_sum < SAT_LO)
            w_uk = OUT_W'(OUT18_MIN);
        else
            w_uk = w_sum[OUT_W-1:0];

        if (w_uk >= w_omax_s)
            w_drive = r_omax;
        else if (w_uk <= w_omin_s)
            w_drive = r_omin;
        else
            w_drive = w_uk[DRV_W-1:0];
    end

    assign adv4 = rdy4 && r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_prev_out <= PREV_OUT_RESET;
        else if (adv4)
            r_prev_out <= w_uk;
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_out.drive       <= w_drive;
            r_out.integrating <= w_integ;
        end
    end

    assign o_out_data = r_out;

endmodule
